>>> rtl/cubic_bezier_chord_length_top_macros.svh
// assertion macros for the bezier chord length block
// no dependencies
`ifndef CUBIC_BEZIER_CHORD_LENGTH_TOP_MACROS_SVH
`define CUBIC_BEZIER_CHORD_LENGTH_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BCL_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define BCL_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define BCL_ASSERT_IMP(label, clk, rst_n, a, c)
`define BCL_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/bcl_pkg.sv
// shared types and constants for the bezier chord length block
// no dependencies
`default_nettype none
package bcl_pkg;
    localparam int MaxSegments = 256;
    localparam int SegW = 9;
    localparam int CoordW = 16;
    localparam int LenW = 19;
    localparam int TW = 17;
    localparam int WW = 49;
    localparam int ProdW = CoordW + WW + 1;
    localparam int PtW = 22;
    localparam int SqW = 46;
    localparam int RootW = SqW;
    localparam int TotW = 32;

    typedef struct packed {
        logic signed [3:0][CoordW-1:0] px;
        logic signed [3:0][CoordW-1:0] py;
        logic [SegW-1:0]               seg;
    } t_job;

    typedef struct packed {
        logic [LenW-1:0] length;
        logic            saturated;
    } t_res;
endpackage
`default_nettype wire

>>> rtl/bcl_front.sv
// front end: takes a curve, clamps the segment count, pushes a job into a 2-entry queue
// depends on bcl_pkg
`default_nettype none
module bcl_front import bcl_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire logic signed [CoordW-1:0] i_x0, i_x1, i_x2, i_x3,
    input  wire logic signed [CoordW-1:0] i_y0, i_y1, i_y2, i_y3,
    input  wire logic [SegW-1:0]          i_seg,
    output logic                          o_valid,
    output t_job                          o_job,
    input  wire logic                     i_take
);
    t_job        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_job        n_job;

    always_comb begin
        n_job.px = {i_x3, i_x2, i_x1, i_x0};
        n_job.py = {i_y3, i_y2, i_y1, i_y0};
        if (i_seg == '0) begin
            n_job.seg = SegW'(1);
        end else if (i_seg > SegW'(MaxSegments)) begin
            n_job.seg = SegW'(MaxSegments);
        end else begin
            n_job.seg = i_seg;
        end
    end

    assign full    = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push && !full) begin
            r_q[r_wp] <= n_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push && !full) r_wp <= ~r_wp;
            if (i_take && o_valid) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'((push && !full) ? 1 : 0) - 2'((i_take && o_valid) ? 1 : 0);
        end
    end
endmodule
`default_nettype wire

>>> rtl/bcl_back.sv
// back end: sequencer evaluating samples with a serial multiply-accumulate, iterative square root
// depends on bcl_pkg
`default_nettype none
module bcl_back import bcl_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_job i_job,
    output logic      o_take,
    output logic      o_done,
    output t_res      o_res,
    input  wire logic i_res_free
);
    typedef enum logic [3:0] {
        S_IDLE, S_T, S_U2, S_U3, S_W, S_MAC, S_DIFF, S_SQX, S_SQY, S_ROOT, S_OUT
    } t_state;

    t_state               r_state;
    t_job                 r_job;
    logic [SegW-1:0]      r_i;
    logic [SegW+16:0]     r_num;
    logic [TW-1:0]        r_t, r_u;
    logic [33:0]          r_t2, r_u2, r_tu;
    logic [WW-1:0]        r_w [4];
    logic [2:0]           r_k;
    logic signed [ProdW+1:0] r_ax, r_ay;
    logic signed [PtW-1:0]   r_x0, r_y0, r_dx, r_dy;
    logic [SqW-1:0]       r_sq, r_rem;
    logic [RootW-1:0]     r_root;
    logic [4:0]           r_bit;
    logic [TotW-1:0]      r_tot;
    logic                 r_first;
    logic [4:0]           r_dc;
    logic [16:0]          r_q;
    logic [SegW+16:0]     r_rr;
    logic [RootW:0]       n_trial;
    logic [SqW-1:0]       n_bitv;
    logic [TotW-5:0]      n_len;
    logic signed [ProdW+1:0] n_px, n_py;
    logic [1:0]           n_kx;
    logic [SegW+17:0]     n_rs;
    logic [SegW+17:0]     n_seg;

    assign o_take = (r_state == S_IDLE) && i_valid;
    assign n_kx   = r_k[1:0];
    assign n_px   = $signed(r_job.px[n_kx]) * $signed({1'b0, r_w[n_kx]});
    assign n_py   = $signed(r_job.py[n_kx]) * $signed({1'b0, r_w[n_kx]});
    assign n_bitv = SqW'(1) << {r_bit, 1'b0};
    assign n_trial = {1'b0, r_root} + {1'b0, n_bitv};
    assign n_len  = r_tot[TotW-1:4];
    assign n_rs   = {r_rr, r_num[5'(SegW+16) - r_dc]};
    assign n_seg  = (SegW+18)'(r_job.seg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_job   <= i_job;
                        r_i     <= '0;
                        r_tot   <= '0;
                        r_first <= 1'b1;
                        r_num   <= '0;
                        r_state <= S_T;
                        r_dc    <= '0;
                        r_rr    <= '0;
                        r_q     <= '0;
                    end
                end
                // restoring divide: t = floor(i*65536/seg), one quotient bit a cycle
                S_T: begin
                    if (r_dc == 5'd26) begin
                        r_t     <= r_q;
                        r_u     <= 17'h10000 - r_q;
                        r_state <= S_U2;
                    end else begin
                        if (n_rs >= n_seg) begin
                            r_rr <= (SegW+17)'(n_rs - n_seg);
                            r_q  <= {r_q[15:0], 1'b1};
                        end else begin
                            r_rr <= (SegW+17)'(n_rs);
                            r_q  <= {r_q[15:0], 1'b0};
                        end
                        r_dc <= r_dc + 5'd1;
                    end
                end
                S_U2: begin
                    r_t2 <= r_t * r_t;
                    r_u2 <= r_u * r_u;
                    r_tu <= r_t * r_u;
                    r_state <= S_U3;
                end
                S_U3: begin
                    r_w[0] <= WW'(r_u2 * r_u);
                    r_w[1] <= WW'(3 * (r_tu * r_u));
                    r_w[2] <= WW'(3 * (r_tu * r_t));
                    r_w[3] <= WW'(r_t2 * r_t);
                    r_k  <= '0;
                    r_ax <= '0;
                    r_ay <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (r_k == 3'd4) begin
                        r_state <= S_DIFF;
                    end else begin
                        r_ax <= r_ax + n_px;
                        r_ay <= r_ay + n_py;
                        r_k  <= r_k + 3'd1;
                    end
                end
                S_DIFF: begin
                    r_x0 <= PtW'(r_ax >>> 44);
                    r_y0 <= PtW'(r_ay >>> 44);
                    r_dx <= PtW'(r_ax >>> 44) - r_x0;
                    r_dy <= PtW'(r_ay >>> 44) - r_y0;
                    if (r_first) begin
                        r_first <= 1'b0;
                        r_state <= S_W;
                    end else begin
                        r_state <= S_SQX;
                    end
                end
                S_SQX: begin
                    r_sq <= SqW'(r_dx * r_dx);
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_rem  <= r_sq + SqW'(r_dy * r_dy);
                    r_root <= '0;
                    r_bit  <= 5'd22;
                    r_state <= S_ROOT;
                end
                // one result bit a cycle
                S_ROOT: begin
                    if ({1'b0, r_rem} >= n_trial) begin
                        r_rem  <= r_rem - SqW'(n_trial);
                        r_root <= (r_root >> 1) + n_bitv;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    if (r_bit == 5'd0) r_state <= S_W;
                    else r_bit <= r_bit - 5'd1;
                end
                S_W: begin
                    if (r_state == S_W && !r_first && r_i != '0) begin
                        r_tot <= r_tot + TotW'(r_root);
                    end
                    if (r_i == r_job.seg) begin
                        r_state <= S_OUT;
                    end else begin
                        r_i   <= r_i + SegW'(1);
                        r_num <= r_num + (SegW+17)'(17'h10000);
                        r_dc  <= '0;
                        r_rr  <= '0;
                        r_q   <= '0;
                        r_state <= S_T;
                    end
                end
                S_OUT: begin
                    if (i_res_free) begin
                        o_done <= 1'b1;
                        if (n_len > (TotW-4)'(19'h7FFFF)) begin
                            o_res.length    <= '1;
                            o_res.saturated <= 1'b1;
                        end else begin
                            o_res.length    <= LenW'(n_len);
                            o_res.saturated <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state != S_OUT || !i_res_free) o_done <= 1'b0;
        end
    end
endmodule
`default_nettype wire

>>> rtl/cubic_bezier_chord_length_top.sv
// cubic bezier chord length, used as a pair of queues.
// push a curve (four x, four y control values in signed Q11.4, a segment
// count) while full is low; read length (Q.4) and saturated while empty is low,
// pop to take it. one result per curve, in order.
// a two-entry job queue sits in front of the evaluator, and a result queue
// behind it, so input and output stall on their own.
// each curve passes through the evaluator segment by segment: per segment a
// bit-serial divide for t, two weight steps, a multiply-accumulate over the
// four control points, a difference, two squares, a bit-serial square
// root and an add; a curve also has an accept step and a hand-off step.
// curves are handled one at a time.
// zero segments count as one, counts above 256 are clamped.
// reset (synchronous, active low) empties both queues and idles the evaluator.
// when the receiver holds off, a finished result waits in the evaluator until
// the result queue is empty, then the job queue fills and full goes high.
// depends on bcl_pkg, bcl_front, bcl_back and the macros header
`default_nettype none
`include "cubic_bezier_chord_length_top_macros.svh"
module cubic_bezier_chord_length_top import bcl_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire logic signed [CoordW-1:0] i_ctrl_x0, i_ctrl_x1, i_ctrl_x2, i_ctrl_x3,
    input  wire logic signed [CoordW-1:0] i_ctrl_y0, i_ctrl_y1, i_ctrl_y2, i_ctrl_y3,
    input  wire logic [SegW-1:0]          i_segments,
    output logic                          empty,
    input  wire logic                     pop,
    output logic [LenW-1:0]               o_length,
    output logic                          o_saturated
);
    logic       w_valid, w_take, w_done;
    t_job       w_job;
    t_res       w_res;
    t_res       r_oq [2];
    logic       r_owp, r_orp;
    logic [1:0] r_ocnt;
    logic       w_pop;

    bcl_front u_front (
        .i_clk, .i_rst_n, .push, .full,
        .i_x0(i_ctrl_x0), .i_x1(i_ctrl_x1), .i_x2(i_ctrl_x2), .i_x3(i_ctrl_x3),
        .i_y0(i_ctrl_y0), .i_y1(i_ctrl_y1), .i_y2(i_ctrl_y2), .i_y3(i_ctrl_y3),
        .i_seg(i_segments), .o_valid(w_valid), .o_job(w_job), .i_take(w_take)
    );

    // evaluator hands a result over only into an empty result queue
    bcl_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_valid), .i_job(w_job), .o_take(w_take),
        .o_done(w_done), .o_res(w_res), .i_res_free(r_ocnt == 2'd0)
    );

    assign empty       = (r_ocnt == 2'd0);
    assign w_pop       = pop && !empty;
    assign o_length    = r_oq[r_orp].length;
    assign o_saturated = r_oq[r_orp].saturated;

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_oq[r_owp] <= w_res;
        end
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_done) r_owp <= ~r_owp;
            if (w_pop) r_orp <= ~r_orp;
            r_ocnt <= r_ocnt + 2'(w_done ? 1 : 0) - 2'(w_pop ? 1 : 0);
        end
    end

    `BCL_ASSERT_IMP(a_no_ovf, i_clk, i_rst_n, w_done, r_ocnt != 2'd2)
    `BCL_ASSERT_IMP(a_sat_len, i_clk, i_rst_n, !empty && o_saturated, o_length == '1)
    `BCL_ASSERT_NXT(a_take_job, i_clk, i_rst_n, w_take, !w_take)
endmodule
`default_nettype wire
